// ----- rtl/fpt_pkg.sv -----
// Shared types and constants of the PCM fractional position timer.
package fpt_pkg;

  // Field widths
  localparam int OP_W       = 2;
  localparam int TICKS_W    = 16;
  localparam int RATE_W     = 18;
  localparam int FRAMES_W   = 17;
  localparam int POS_W      = 16;
  localparam int CNT_W      = 16;
  localparam int TTN_W      = 14;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 18;

  // Ticks times rate, and the widest value the dividers take
  localparam int D_W    = TICKS_W + RATE_W;
  localparam int DIV_W  = D_W + 1;
  localparam int STEP_W = $clog2(DIV_W + 1);

  // Saturation limits
  localparam int unsigned POS_MAX = 65535;
  localparam int unsigned CNT_MAX = 65535;
  localparam int unsigned TTN_MAX = 16383;

  // Configuration reset values
  localparam int unsigned SAMPLE_RATE_RST   = 48000;
  localparam int unsigned BUFFER_FRAMES_RST = 4096;
  localparam int unsigned PERIOD_FRAMES_RST = 1024;

  // Operation codes
  localparam logic [OP_W-1:0] OP_RESTART = 2'd0;
  localparam logic [OP_W-1:0] OP_QUERY   = 2'd1;
  localparam logic [OP_W-1:0] OP_SERVICE = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_FRAMES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD_FRAMES = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [TICKS_W-1:0] ticks_elapsed;
  } fpt_in_t;

  typedef struct packed {
    logic [POS_W-1:0] position_frames;
    logic [CNT_W-1:0] periods_elapsed;
    logic [TTN_W-1:0] ticks_to_next_period;
  } fpt_out_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic mul;
    logic restart;
    logic adv_start;
    logic adv_commit;
    logic ttn_start;
    logic out_load;
  } fpt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ticks_zero;
    logic            busy;
  } fpt_sts_t;

endpackage

// ----- rtl/pcm_fractional_position_timer.sv -----
// A query or service with nonzero ticks runs the advance division and then the ceiling
// tick division; a restart, a zero-tick item or op 3 runs only the ceiling tick division.
// Two bit-serial dividers do the work: 35 steps for ring modulo and period count in parallel,
// then FW+1 = 28 steps (TICK_RATE 1000) for the ceiling tick count; frame position is a
// reciprocal multiply. One transaction at a time; the next is taken the cycle after the result loads.
// Reset (synchronous, rst_n low) restores the register defaults and clears position and count.
module pcm_fractional_position_timer #(
  parameter int TICK_RATE = 1000
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  fpt_pkg::fpt_in_t               in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output fpt_pkg::fpt_out_t              out_data
);
  import fpt_pkg::*;

  fpt_cmd_t cmd;
  fpt_sts_t sts;

  fpt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  fpt_datapath #(.TICK_RATE(TICK_RATE)) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .out_data  (out_data),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ----- rtl/fpt_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
module fpt_div #(
  parameter int DVS_W = 27
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fpt_pkg::DIV_W-1:0]   dividend,
  input  logic [DVS_W-1:0]            divisor,
  input  logic [fpt_pkg::STEP_W-1:0]  steps,
  output logic                        busy,
  output logic [fpt_pkg::DIV_W-1:0]   quotient,
  output logic [DVS_W-1:0]            remainder
);
  import fpt_pkg::*;

  logic [DIV_W-1:0]  num_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DVS_W-1:0]  rem_r;
  logic [DVS_W-1:0]  dvs_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;

  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             take;
  logic [DVS_W-1:0] rem_nxt;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial   = {rem_r, num_r[DIV_W-1]};
    diff    = trial - {1'b0, dvs_r};
    take    = (trial >= {1'b0, dvs_r});
    rem_nxt = take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
  end

  // Step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= (steps != '0);
      cnt_r  <= steps;
    end else if (busy_r) begin
      busy_r <= (cnt_r != STEP_W'(1));
      cnt_r  <= cnt_r - STEP_W'(1);
    end
  end

  // Operand and result registers
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      quo_r <= {quo_r[DIV_W-2:0], take};
    end
  end

  assign busy      = busy_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

// ----- rtl/fpt_ctrl.sv -----
// Sequencing state machine of the position timer.
module fpt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  fpt_pkg::fpt_sts_t sts,
  output fpt_pkg::fpt_cmd_t cmd
);
  import fpt_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_MUL    = 6'b000010,
    ST_PREP   = 6'b000100,
    ST_ADV    = 6'b001000,
    ST_TSTART = 6'b010000,
    ST_TWAIT  = 6'b100000
  } fpt_state_t;

  fpt_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_PREP;
      end
      ST_PREP: begin
        state_nxt = ST_TSTART;
        unique case (sts.op) inside
          OP_RESTART: cmd.restart = 1'b1;
          OP_QUERY, OP_SERVICE: begin
            if (!sts.ticks_zero) begin
              cmd.adv_start = 1'b1;
              state_nxt     = ST_ADV;
            end
          end
          default: ;
        endcase
      end
      // wait for the modulo and period division
      ST_ADV: begin
        if (!sts.busy) begin
          cmd.adv_commit = 1'b1;
          state_nxt      = ST_TSTART;
        end
      end
      ST_TSTART: begin
        cmd.ttn_start = 1'b1;
        state_nxt     = ST_TWAIT;
      end
      // wait for the tick division and a free output register
      ST_TWAIT: begin
        if (!sts.busy && (!out_valid_r || !out_stall)) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ----- rtl/fpt_datapath.sv -----
// Datapath: configuration, position and period state, dividers, result register.
module fpt_datapath #(
  parameter int TICK_RATE = 1000
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fpt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fpt_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  fpt_pkg::fpt_in_t               in_data,
  output fpt_pkg::fpt_out_t              out_data,
  input  fpt_pkg::fpt_cmd_t              cmd,
  output fpt_pkg::fpt_sts_t              sts
);
  import fpt_pkg::*;

  // Width of fractional values: frames times tick rate
  localparam int FW = $clog2(((1 << FRAMES_W) - 1) * TICK_RATE + 1);
  localparam logic [FW-1:0] REST_RST = FW'(PERIOD_FRAMES_RST * TICK_RATE);

  // Reciprocal of the tick rate, exact for any FW-bit position
  localparam int REC_SH = FW + $clog2(TICK_RATE);
  localparam int REC_W  = FW + 1;
  localparam int PQ_W   = FW + REC_W - REC_SH;
  localparam logic [REC_W-1:0] REC_M =
    REC_W'(((64'd1 << REC_SH) + 64'(TICK_RATE) - 64'd1) / 64'(TICK_RATE));

  // Configuration
  logic [RATE_W-1:0]   sr_r;
  logic [FRAMES_W-1:0] bf_r;
  logic [FRAMES_W-1:0] pf_r;

  // Transaction and products
  logic [OP_W-1:0]    op_r;
  logic [TICKS_W-1:0] ticks_r;
  logic [D_W-1:0]     d_r;
  logic [FW-1:0]      fb_r;
  logic [FW-1:0]      fp_r;

  // Timer state
  logic [FW-1:0]    pos_r;
  logic [FW-1:0]    rest_r;
  logic [CNT_W-1:0] cnt_r;
  logic             use_a_r;
  logic             use_b_r;
  fpt_out_t         out_data_r;

  // Divider ports
  logic             start_a, start_b, busy_a, busy_b;
  logic [DIV_W-1:0] dvd_a, dvd_b, quo_a, quo_b;
  logic [FW-1:0]    dvs_a, dvs_b, rem_a, rem_b;
  logic [STEP_W-1:0] steps_a, steps_b;

  logic [DIV_W-1:0]      pos_sum;
  logic [D_W-1:0]        d_minus_rest;
  logic                  rest_gt_d;
  logic [FW-1:0]         sr_ext;
  logic [FW:0]           ttn_num;
  logic [DIV_W:0]        cnt_sum;
  logic [CNT_W-1:0]      cnt_sat;
  logic [FW+REC_W-1:0]   pos_prod;
  logic [PQ_W-1:0]       pos_quo;
  logic [POS_W-1:0]      pos_frames;
  logic [TTN_W-1:0]      ttn_sat;

  // Advance and ceiling arithmetic
  always_comb begin
    pos_sum      = {{(DIV_W-FW){1'b0}}, pos_r} + {1'b0, d_r};
    d_minus_rest = d_r - {{(D_W-FW){1'b0}}, rest_r};
    rest_gt_d    = ({{(D_W-FW){1'b0}}, rest_r} > d_r);
    sr_ext       = {{(FW-RATE_W){1'b0}}, sr_r};
    ttn_num      = {1'b0, rest_r} + {1'b0, sr_ext} - (FW+1)'(1);
    cnt_sum      = {{(DIV_W+1-CNT_W){1'b0}}, cnt_r} + {1'b0, quo_a} + (DIV_W+1)'(1);
    cnt_sat      = (cnt_sum > (DIV_W+1)'(CNT_MAX)) ? CNT_W'(CNT_MAX) : cnt_sum[CNT_W-1:0];
    // frame position: multiply by the reciprocal, keep the high part
    pos_prod     = (FW+REC_W)'(pos_r) * (FW+REC_W)'(REC_M);
    pos_quo      = pos_prod[FW+REC_W-1:REC_SH];
    pos_frames   = (pos_quo > PQ_W'(POS_MAX)) ? POS_W'(POS_MAX) : pos_quo[POS_W-1:0];
    ttn_sat      = ((sr_r == '0) || (quo_b > DIV_W'(TTN_MAX))) ?
                   TTN_W'(TTN_MAX) : quo_b[TTN_W-1:0];
  end

  // Divider A: crossed periods
  always_comb begin
    start_a = cmd.adv_start && !rest_gt_d && (fp_r != '0);
    dvd_a   = {1'b0, d_minus_rest};
    dvs_a   = fp_r;
    steps_a = STEP_W'(DIV_W);
  end

  // Divider B: position modulo the ring, then ticks to the next boundary
  always_comb begin
    start_b = (cmd.adv_start && (fb_r != '0)) || cmd.ttn_start;
    if (cmd.ttn_start) begin
      dvd_b   = {ttn_num, {(DIV_W-FW-1){1'b0}}};
      dvs_b   = sr_ext;
      steps_b = STEP_W'(FW + 1);
    end else begin
      dvd_b   = pos_sum;
      dvs_b   = fb_r;
      steps_b = STEP_W'(DIV_W);
    end
  end

  fpt_div #(.DVS_W(FW)) u_div_a (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_a),
    .dividend  (dvd_a),
    .divisor   (dvs_a),
    .steps     (steps_a),
    .busy      (busy_a),
    .quotient  (quo_a),
    .remainder (rem_a)
  );

  fpt_div #(.DVS_W(FW)) u_div_b (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start_b),
    .dividend  (dvd_b),
    .divisor   (dvs_b),
    .steps     (steps_b),
    .busy      (busy_b),
    .quotient  (quo_b),
    .remainder (rem_b)
  );

  // Configuration and timer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r    <= RATE_W'(SAMPLE_RATE_RST);
      bf_r    <= FRAMES_W'(BUFFER_FRAMES_RST);
      pf_r    <= FRAMES_W'(PERIOD_FRAMES_RST);
      pos_r   <= '0;
      rest_r  <= REST_RST;
      cnt_r   <= '0;
      use_a_r <= 1'b0;
      use_b_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SAMPLE_RATE:   sr_r <= cfg_wdata[RATE_W-1:0];
          REG_BUFFER_FRAMES: bf_r <= cfg_wdata[FRAMES_W-1:0];
          REG_PERIOD_FRAMES: pf_r <= cfg_wdata[FRAMES_W-1:0];
          default: ;
        endcase
      end
      if (cmd.restart) begin
        pos_r  <= '0;
        rest_r <= fp_r;
        cnt_r  <= '0;
      end
      // start of an advance: settle the cases that need no division
      if (cmd.adv_start) begin
        use_b_r <= (fb_r != '0);
        if (fb_r == '0) pos_r <= '0;
        if (rest_gt_d) begin
          rest_r  <= rest_r - d_r[FW-1:0];
          use_a_r <= 1'b0;
        end else if (fp_r == '0) begin
          rest_r  <= '0;
          use_a_r <= 1'b0;
        end else begin
          use_a_r <= 1'b1;
        end
      end
      if (cmd.adv_commit) begin
        if (use_b_r) pos_r <= rem_b;
        if (use_a_r) begin
          rest_r <= fp_r - rem_a;
          cnt_r  <= cnt_sat;
        end
      end
      // service clears the count once it has been reported
      if (cmd.out_load && (op_r == OP_SERVICE)) cnt_r <= '0;
    end
  end

  // Transaction capture, products and result register
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r    <= in_data.op;
      ticks_r <= in_data.ticks_elapsed;
    end
    if (cmd.mul) begin
      d_r  <= D_W'(ticks_r) * D_W'(sr_r);
      fb_r <= FW'(bf_r) * FW'(TICK_RATE);
      fp_r <= FW'(pf_r) * FW'(TICK_RATE);
    end
    if (cmd.out_load) begin
      out_data_r.position_frames      <= pos_frames;
      out_data_r.periods_elapsed      <= cnt_r;
      out_data_r.ticks_to_next_period <= ttn_sat;
    end
  end

  assign out_data       = out_data_r;
  assign sts.op         = op_r;
  assign sts.ticks_zero = (ticks_r == '0);
  assign sts.busy       = busy_a | busy_b;

endmodule

// ----- rtl/fpt_checker.sv -----
// Port-level assertions for the position timer and their bind.
module fpt_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_stall,
  input fpt_pkg::fpt_in_t  in_data,
  input logic              out_valid,
  input logic              out_stall,
  input fpt_pkg::fpt_out_t out_data
);
  import fpt_pkg::*;

  // No result survives a reset
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // One transaction at a time: input is stalled right after an accept
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted while a transaction is in flight");

  // A result only appears at the end of work, while input was held off
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a transaction in flight");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind pcm_fractional_position_timer fpt_checker u_fpt_checker (.*);

// ----- bench/pcm_fractional_position_timer_test.sv -----
// Self-checking testbench for the PCM fractional position timer.
`timescale 1ns / 1ps

module pcm_fractional_position_timer_test;
  import fpt_pkg::*;

  localparam int unsigned TICK_RATE          = 1000;
  localparam int          WATCHDOG_LIMIT     = 4000;
  localparam int          DRAIN_CYCLES       = 80;
  localparam int          HOLD_CYCLES        = 400;
  localparam int          RANDOM_PHASE_ITEMS = 175;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // Block ports; the inputs are known from time zero
  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_SAMPLE_RATE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  fpt_in_t               in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  fpt_out_t              out_data;

  pcm_fractional_position_timer #(
    .TICK_RATE(TICK_RATE)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #1 clk = ~clk;

  // Pointer state and register copies kept by the predictor
  logic [RATE_W-1:0]   rate_cfg;
  logic [FRAMES_W-1:0] buffer_cfg;
  logic [FRAMES_W-1:0] period_cfg;
  logic [31:0]         pos_fraction;
  logic [31:0]         period_left;
  logic [CNT_W-1:0]    period_cnt;
  fpt_out_t            expected_reports[$];

  // Traffic shaping and bookkeeping
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct    = 0;
  bit          hold_pending = 1'b0;
  int unsigned hold_left    = 0;
  int unsigned burst_left   = 0;
  int unsigned quiet_cycles = 0;
  int unsigned items_sent   = 0;
  int unsigned reports_ok   = 0;
  int unsigned mismatches   = 0;
  int unsigned configs_used = 0;

  // Move the pointer by ticks * rate; count crossed period boundaries
  function automatic void advance_pointer(input logic [TICKS_W-1:0] ticks);
    longint unsigned d, ring, per, rest, n, total;
    d = ticks;
    d = d * rate_cfg;
    ring = buffer_cfg;
    ring = ring * TICK_RATE;
    per = period_cfg;
    per = per * TICK_RATE;
    if (ring == 0)
      pos_fraction = '0;
    else
      pos_fraction = 32'((pos_fraction + d) % ring);
    rest = period_left;
    if (rest > d) begin
      rest = rest - d;
    end else if (per == 0) begin
      rest = 0;
    end else begin
      n = (d - rest) / per + 1;
      total = period_cnt + n;
      period_cnt = (total > CNT_MAX) ? CNT_W'(CNT_MAX) : CNT_W'(total);
      rest = rest + n * per - d;
    end
    period_left = 32'(rest);
  endfunction

  // Apply one transaction to the pointer state and build its report
  function automatic fpt_out_t pointer_step(input fpt_in_t item);
    fpt_out_t        rep;
    longint unsigned pos, ttn;
    if (item.op == OP_RESTART) begin
      pos_fraction = '0;
      period_left = 32'(period_cfg * TICK_RATE);
      period_cnt = '0;
    end else if ((item.op == OP_QUERY || item.op == OP_SERVICE) &&
                 item.ticks_elapsed != '0) begin
      advance_pointer(item.ticks_elapsed);
    end
    pos = pos_fraction / TICK_RATE;
    rep.position_frames = (pos > POS_MAX) ? POS_W'(POS_MAX) : POS_W'(pos);
    rep.periods_elapsed = period_cnt;
    if (rate_cfg == '0) begin
      ttn = TTN_MAX;
    end else begin
      ttn = period_left;
      ttn = (ttn + rate_cfg - 1) / rate_cfg;
      if (ttn > TTN_MAX)
        ttn = TTN_MAX;
    end
    rep.ticks_to_next_period = TTN_W'(ttn);
    // service clears the count after reporting it
    if (item.op == OP_SERVICE)
      period_cnt = '0;
    return rep;
  endfunction

  // Mostly short tick counts (1 to 64), some up to 2047, the rest any 16-bit value
  function automatic logic [TICKS_W-1:0] random_ticks();
    case ($urandom_range(3))
      0, 1: return TICKS_W'($urandom_range(64, 1));
      2: return TICKS_W'($urandom_range(2047, 1));
      default: return TICKS_W'($urandom());
    endcase
  endfunction

  // Offer one transaction, hold it until taken, then record its report
  task automatic send_item(input logic [OP_W-1:0] op, input logic [TICKS_W-1:0] ticks);
    int unsigned gap;
    fpt_in_t     item;
    gap = 0;
    if ($urandom_range(99) < send_gap_pct)
      gap = ($urandom_range(7) == 0) ? $urandom_range(90, 1) : $urandom_range(3, 1);
    item.op = op;
    item.ticks_elapsed = ticks;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (in_stall !== 1'b0);
    expected_reports.push_back(pointer_step(item));
    items_sent++;
  endtask

  // Stop offering and let every outstanding report come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write all three registers on back-to-back cycles; block must be idle
  task automatic set_config(input int unsigned rate, input int unsigned ring,
                            input int unsigned per);
    cfg_we <= 1'b1;
    cfg_index <= REG_SAMPLE_RATE;
    cfg_wdata <= CFG_DATA_W'(rate);
    @(posedge clk);
    cfg_index <= REG_BUFFER_FRAMES;
    cfg_wdata <= CFG_DATA_W'(ring);
    @(posedge clk);
    cfg_index <= REG_PERIOD_FRAMES;
    cfg_wdata <= CFG_DATA_W'(per);
    @(posedge clk);
    cfg_we <= 1'b0;
    rate_cfg = RATE_W'(rate);
    buffer_cfg = FRAMES_W'(ring);
    period_cfg = FRAMES_W'(per);
    configs_used++;
  endtask

  // Default registers: zero ticks, first boundary crossing, max ticks, op 3
  task automatic test_reset_defaults();
    send_item(OP_QUERY, '0);
    send_item(OP_QUERY, 16'd1);
    send_item(OP_QUERY, 16'd21);
    send_item(OP_SERVICE, 16'd22);
    send_item(OP_UNUSED, 16'd5);
    send_item(OP_QUERY, 16'hFFFF);
    send_item(OP_SERVICE, '0);
    send_item(OP_RESTART, 16'hFFFF);
    wait_idle();
  endtask

  // Register range limits; tiny periods push the count into saturation
  task automatic test_register_extremes();
    set_config(192000, 65536, 65536);
    send_item(OP_RESTART, '0);
    send_item(OP_QUERY, 16'hFFFF);
    send_item(OP_SERVICE, 16'hFFFF);
    send_item(OP_QUERY, 16'd1);
    wait_idle();
    set_config(8000, 1, 1);
    send_item(OP_RESTART, '0);
    send_item(OP_QUERY, 16'hFFFF);
    send_item(OP_SERVICE, 16'd1);
    send_item(OP_QUERY, 16'd1);
    wait_idle();
  endtask

  // Zero period, zero buffer, zero rate and oversized register values
  task automatic test_special_cases();
    // zero period: remainder runs down and stops at zero
    set_config(48000, 0, 0);
    send_item(OP_QUERY, 16'd1);
    send_item(OP_QUERY, 16'hFFFF);
    wait_idle();
    set_config(0, 0, 0);
    send_item(OP_QUERY, 16'd100);
    send_item(OP_RESTART, '0);
    wait_idle();
    // all-ones write data: buffer and period truncate to 17 bits
    set_config(262143, 262143, 262143);
    send_item(OP_RESTART, '0);
    send_item(OP_QUERY, 16'd300);
    send_item(OP_QUERY, 16'hFFFF);
    wait_idle();
    // one frame per second: tick count to boundary saturates
    set_config(1, 4096, 131071);
    send_item(OP_RESTART, '0);
    wait_idle();
  endtask

  // One random phase: fresh registers, restart-led runs plus some noise
  task automatic run_random_phase(input int unsigned gap_pct, input int unsigned hold_pct);
    int unsigned rate, ring, per, left, run;
    case ($urandom_range(3))
      0: rate = 8000;
      1: rate = 192000;
      default: rate = $urandom_range(192000, 8000);
    endcase
    case ($urandom_range(3))
      0: ring = 1;
      1: ring = 65536;
      default: ring = $urandom_range(16384, 64);
    endcase
    case ($urandom_range(3))
      0: per = 1;
      1: per = 65536;
      default: per = $urandom_range(8192, 16);
    endcase
    set_config(rate, ring, per);
    send_gap_pct = gap_pct;
    stall_pct = hold_pct;
    left = RANDOM_PHASE_ITEMS;
    while (left != 0) begin
      if ($urandom_range(9) < 8) begin
        send_item(OP_RESTART, random_ticks());
        left--;
        run = $urandom_range(40, 4);
        while (run != 0 && left != 0) begin
          send_item(($urandom_range(2) == 0) ? OP_SERVICE : OP_QUERY, random_ticks());
          run--;
          left--;
        end
      end else begin
        case ($urandom_range(2))
          0: send_item(OP_UNUSED, random_ticks());
          1: begin
            send_item(($urandom_range(1) == 0) ? OP_QUERY : OP_SERVICE, '0);
            left--;
          end
          default: begin
            send_item(OP_RESTART, '0);
            left--;
          end
        endcase
      end
    end
    wait_idle();
    send_gap_pct = 0;
    stall_pct = 0;
  endtask

  // Each idle mix twice, each time under new registers
  task automatic test_idle_mixes();
    repeat (2) begin
      run_random_phase(0, 0);
      run_random_phase(51, 0);
      run_random_phase(0, 51);
      run_random_phase(17, 17);
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering
  task automatic test_result_backpressure();
    hold_pending = 1'b1;
    send_item(OP_RESTART, '0);
    repeat (11)
      send_item(($urandom_range(1) == 0) ? OP_QUERY : OP_SERVICE, random_ticks());
    wait_idle();
  endtask

  // Receiver stall: long hold on request, else random stalls and bursts
  always @(posedge clk) begin
    if (hold_pending) begin
      hold_pending = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (burst_left != 0) begin
      burst_left--;
      out_stall <= 1'b1;
    end else if ($urandom_range(99) < stall_pct) begin
      out_stall <= 1'b1;
      if ($urandom_range(9) == 0)
        burst_left = $urandom_range(40, 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare each accepted report against the oldest prediction
  always @(posedge clk) begin : report_check
    fpt_out_t want;
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: report with none pending: pos=%0d cnt=%0d ttn=%0d",
                   out_data.position_frames, out_data.periods_elapsed,
                   out_data.ticks_to_next_period);
      end else begin
        want = expected_reports.pop_front();
        if (out_data.position_frames !== want.position_frames ||
            out_data.periods_elapsed !== want.periods_elapsed ||
            out_data.ticks_to_next_period !== want.ticks_to_next_period) begin
          mismatches++;
          if (mismatches <= 10)
            $display("tb: mismatch: expected pos=%0d cnt=%0d ttn=%0d, got pos=%0d cnt=%0d ttn=%0d",
                     want.position_frames, want.periods_elapsed,
                     want.ticks_to_next_period, out_data.position_frames,
                     out_data.periods_elapsed, out_data.ticks_to_next_period);
        end else begin
          reports_ok++;
        end
      end
    end
  end

  // Watchdog: too many cycles with no transaction on either side
  always @(posedge clk) begin
    if (!rst_n || (in_valid === 1'b1 && in_stall === 1'b0) ||
        (out_valid === 1'b1 && out_stall === 1'b0)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rate_cfg = RATE_W'(SAMPLE_RATE_RST);
    buffer_cfg = FRAMES_W'(BUFFER_FRAMES_RST);
    period_cfg = FRAMES_W'(PERIOD_FRAMES_RST);
    pos_fraction = '0;
    period_left = 32'(PERIOD_FRAMES_RST * TICK_RATE);
    period_cnt = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_register_extremes();
    test_special_cases();
    test_idle_mixes();
    test_result_backpressure();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("tb: %0d transactions, %0d reports matched, %0d mismatches, %0d register settings",
             items_sent, reports_ok, mismatches, configs_used);
    $display("tb: covered restart/query/service/op 3, zero and oversized registers, %s",
             "saturation, four idle mixes and a long result hold-off");
    if (mismatches == 0 && expected_reports.size() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
